FILE: src/lfpid_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfpid_pkg
// shared widths, register indexes and reset values of the line follower drive
// ----------------------------------------------------------------------------
package lfpid_pkg;

  // field widths
  localparam int unsigned ERR_W      = 12;
  localparam int unsigned SAMPLE_W   = 10;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned SPEED_W    = 8;
  localparam int unsigned LEVEL_W    = 10;
  localparam int unsigned DRIVE_W    = 9;
  localparam int unsigned SUM_W      = 32;

  // sensor fields carried on the input channel, and how many are examined
  localparam int unsigned NUM_IR_FIELDS = 5;
  localparam int unsigned SENSOR_COUNT  = 5;

  // default fraction bits of the gains
  localparam int unsigned GAIN_FRAC_BITS = 8;

  // channel widths
  localparam int unsigned IN_TDATA_W  = 64;
  localparam int unsigned OUT_TDATA_W = 24;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 16;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // register indexes
  localparam cfg_idx_t REG_PROP_GAIN    = 3'd0;
  localparam cfg_idx_t REG_INTEG_GAIN   = 3'd1;
  localparam cfg_idx_t REG_DERIV_GAIN   = 3'd2;
  localparam cfg_idx_t REG_BASE_SPEED   = 3'd3;
  localparam cfg_idx_t REG_SEARCH_SPEED = 3'd4;
  localparam cfg_idx_t REG_BLACK_LEVEL  = 3'd5;
  localparam cfg_idx_t REG_DRIVE_LIMIT  = 3'd6;

  // reset values
  localparam logic [GAIN_W-1:0]  PROP_GAIN_RST    = 16'd896;
  localparam logic [GAIN_W-1:0]  INTEG_GAIN_RST   = 16'd0;
  localparam logic [GAIN_W-1:0]  DERIV_GAIN_RST   = 16'd0;
  localparam logic [SPEED_W-1:0] BASE_SPEED_RST   = 8'd120;
  localparam logic [SPEED_W-1:0] SEARCH_SPEED_RST = 8'd120;
  localparam logic [LEVEL_W-1:0] BLACK_LEVEL_RST  = 10'd600;
  localparam logic [SPEED_W-1:0] DRIVE_LIMIT_RST  = 8'd150;

endpackage : lfpid_pkg
`default_nettype wire

FILE: src/line_follow_pid_drive_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// line_follow_pid_drive_unit
// pid steering of a line follower with differential wheel drives
// ----------------------------------------------------------------------------
// usage
//   in_*  : one sensor frame per request, line error and reflectance samples
//   out_* : one drive request per frame, left/right wheel drive and lost flag
//   cfg_* : register writes, always ready, only while no frame is in flight;
//   the user must keep to this, the block does not enforce it
// pipeline : out_tvalid is set after five register stages (input register,
//   integral/state stage, multiply stage, sum stage, output register)
// throughput : one frame per cycle while out_tready does not stall the pipe;
//   the integral and last error live in one stage and are updated as a frame
//   enters stage 1, so each frame sees the state left by the one before
// reset : rst_n low empties the pipe, clears integral and last error and
//   loads the default gains, speeds, black level and drive limit
// stall : a stage that holds data keeps it while the next stage is full and
//   stalled; empty stages still take data, so in_tready drops only once
//   every stage is occupied behind a stalled out_tready
// ----------------------------------------------------------------------------
module line_follow_pid_drive_unit #(
  parameter int unsigned GAIN_FRAC_BITS = lfpid_pkg::GAIN_FRAC_BITS
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  // input frame: line_error[11:0], ir_sample_0..4 [21:12]..[61:52], zero pad
  input  wire                                  in_tvalid,
  output logic                                 in_tready,
  input  wire  [lfpid_pkg::IN_TDATA_W-1:0]     in_tdata,
  // result: left_drive[8:0], right_drive[17:9], zero pad
  output logic                                 out_tvalid,
  input  wire                                  out_tready,
  output logic [lfpid_pkg::OUT_TDATA_W-1:0]    out_tdata,
  // result kind: line_lost[0]
  output logic                                 out_tuser,
  // register write channel
  input  wire                                  cfg_valid,
  output logic                                 cfg_ready,
  input  wire  [lfpid_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire  [lfpid_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int unsigned ERR_W    = lfpid_pkg::ERR_W;
  localparam int unsigned SAMPLE_W = lfpid_pkg::SAMPLE_W;
  localparam int unsigned GAIN_W   = lfpid_pkg::GAIN_W;
  localparam int unsigned SPEED_W  = lfpid_pkg::SPEED_W;
  localparam int unsigned LEVEL_W  = lfpid_pkg::LEVEL_W;
  localparam int unsigned DRIVE_W  = lfpid_pkg::DRIVE_W;
  localparam int unsigned SUM_W    = lfpid_pkg::SUM_W;
  localparam int unsigned NUM_IR   = lfpid_pkg::NUM_IR_FIELDS;
  // only the first sensors, up to the fields carried, are looked at
  localparam int unsigned NUM_SENSE = (lfpid_pkg::SENSOR_COUNT < NUM_IR) ?
                                      lfpid_pkg::SENSOR_COUNT : NUM_IR;
  // product widths: unsigned gain (plus sign) times signed operand
  localparam int unsigned PW = GAIN_W + 1 + ERR_W;
  localparam int unsigned IW = GAIN_W + 1 + SUM_W;
  localparam int unsigned DW = GAIN_W + 1 + ERR_W + 1;
  // drive accumulator, headroom for three products and the base
  localparam int unsigned AW = IW + 3;
  localparam int unsigned PAD_W = lfpid_pkg::OUT_TDATA_W - 2 * DRIVE_W;

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [GAIN_W-1:0]  prop_gain_r, integ_gain_r, deriv_gain_r;
  logic [SPEED_W-1:0] base_speed_r, search_speed_r, drive_limit_r;
  logic [LEVEL_W-1:0] black_level_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r    <= lfpid_pkg::PROP_GAIN_RST;
      integ_gain_r   <= lfpid_pkg::INTEG_GAIN_RST;
      deriv_gain_r   <= lfpid_pkg::DERIV_GAIN_RST;
      base_speed_r   <= lfpid_pkg::BASE_SPEED_RST;
      search_speed_r <= lfpid_pkg::SEARCH_SPEED_RST;
      black_level_r  <= lfpid_pkg::BLACK_LEVEL_RST;
      drive_limit_r  <= lfpid_pkg::DRIVE_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lfpid_pkg::REG_PROP_GAIN:    prop_gain_r    <= cfg_data[GAIN_W-1:0];
        lfpid_pkg::REG_INTEG_GAIN:   integ_gain_r   <= cfg_data[GAIN_W-1:0];
        lfpid_pkg::REG_DERIV_GAIN:   deriv_gain_r   <= cfg_data[GAIN_W-1:0];
        lfpid_pkg::REG_BASE_SPEED:   base_speed_r   <= cfg_data[SPEED_W-1:0];
        lfpid_pkg::REG_SEARCH_SPEED: search_speed_r <= cfg_data[SPEED_W-1:0];
        lfpid_pkg::REG_BLACK_LEVEL:  black_level_r  <= cfg_data[LEVEL_W-1:0];
        lfpid_pkg::REG_DRIVE_LIMIT:  drive_limit_r  <= cfg_data[SPEED_W-1:0];
        default: ; // unused index, write dropped
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // pipeline flow control: a stage loads when empty or when it drains
  // --------------------------------------------------------------------------
  logic s0_v_r, s1_v_r, s2_v_r, s3_v_r, out_v_r;
  logic rdy0, rdy1, rdy2, rdy3, rdy_out;
  logic in_acc;

  assign rdy_out   = !out_v_r || out_tready;
  assign rdy3      = !s3_v_r  || rdy_out;
  assign rdy2      = !s2_v_r  || rdy3;
  assign rdy1      = !s1_v_r  || rdy2;
  assign rdy0      = !s0_v_r  || rdy1;
  assign in_tready = rdy0;
  assign in_acc    = in_tvalid && rdy0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r  <= 1'b0;
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (rdy0)    s0_v_r  <= in_acc;
      if (rdy1)    s1_v_r  <= s0_v_r;
      if (rdy2)    s2_v_r  <= s1_v_r;
      if (rdy3)    s3_v_r  <= s2_v_r;
      if (rdy_out) out_v_r <= s3_v_r;
    end
  end

  // --------------------------------------------------------------------------
  // stage 0: input register, frame unpacked
  // --------------------------------------------------------------------------
  logic signed [ERR_W-1:0] s0_err_r;
  logic [SAMPLE_W-1:0]     s0_smp_r [NUM_IR];

  always_ff @(posedge clk) begin
    if (rdy0) begin
      s0_err_r <= $signed(in_tdata[ERR_W-1:0]);
      for (int i = 0; i < NUM_IR; i++) begin
        s0_smp_r[i] <= in_tdata[ERR_W + SAMPLE_W * i +: SAMPLE_W];
      end
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: black detect, saturating integral, derivative, state update
  // --------------------------------------------------------------------------
  logic signed [SUM_W-1:0] err_sum_r, err_sum_nxt;
  logic signed [ERR_W-1:0] last_err_r;
  logic                    lost_nxt;
  logic signed [SUM_W:0]   sum_wide;
  logic signed [ERR_W:0]   diff_nxt;
  logic                    spin_pos_nxt;
  logic                    state_upd;

  always_comb begin
    lost_nxt = 1'b1;
    for (int i = 0; i < NUM_SENSE; i++) begin
      if (s0_smp_r[i] > black_level_r) lost_nxt = 1'b0;
    end
  end

  always_comb begin
    sum_wide = $signed({err_sum_r[SUM_W-1], err_sum_r}) + (SUM_W + 1)'(s0_err_r);
    // clip at the 32-bit signed limits on overflow
    if (sum_wide[SUM_W] != sum_wide[SUM_W-1]) begin
      err_sum_nxt = sum_wide[SUM_W] ? {1'b1, {(SUM_W - 1){1'b0}}}
                                    : {1'b0, {(SUM_W - 1){1'b1}}};
    end else begin
      err_sum_nxt = sum_wide[SUM_W-1:0];
    end
  end

  assign diff_nxt     = (ERR_W + 1)'(s0_err_r) - (ERR_W + 1)'(last_err_r);
  // spin toward the side of the last error: positive runs the right wheel
  // forward and the left wheel back
  assign spin_pos_nxt = !last_err_r[ERR_W-1] && (last_err_r != '0);
  assign state_upd    = rdy1 && s0_v_r && !lost_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_sum_r  <= '0;
      last_err_r <= '0;
    end else if (state_upd) begin
      err_sum_r  <= err_sum_nxt;
      last_err_r <= s0_err_r;
    end
  end

  logic signed [ERR_W-1:0] s1_err_r;
  logic signed [SUM_W-1:0] s1_sum_r;
  logic signed [ERR_W:0]   s1_diff_r;
  logic                    s1_lost_r, s1_spin_pos_r;

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_err_r      <= s0_err_r;
      s1_sum_r      <= err_sum_nxt;
      s1_diff_r     <= diff_nxt;
      s1_lost_r     <= lost_nxt;
      s1_spin_pos_r <= spin_pos_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: the three gain products
  // --------------------------------------------------------------------------
  logic signed [PW-1:0] s2_p_r;
  logic signed [IW-1:0] s2_i_r;
  logic signed [DW-1:0] s2_d_r;
  logic                 s2_lost_r, s2_spin_pos_r;

  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2_p_r        <= $signed({1'b0, prop_gain_r})  * s1_err_r;
      s2_i_r        <= $signed({1'b0, integ_gain_r}) * s1_sum_r;
      s2_d_r        <= $signed({1'b0, deriv_gain_r}) * s1_diff_r;
      s2_lost_r     <= s1_lost_r;
      s2_spin_pos_r <= s1_spin_pos_r;
    end
  end

  // --------------------------------------------------------------------------
  // stage 3: scaled base minus / plus the correction
  // --------------------------------------------------------------------------
  logic signed [AW-1:0] base_s, corr;
  logic signed [AW-1:0] s3_left_r, s3_right_r;
  logic                 s3_lost_r, s3_spin_pos_r;

  assign base_s = $signed(AW'({base_speed_r, {GAIN_FRAC_BITS{1'b0}}}));
  assign corr   = AW'(s2_p_r) + AW'(s2_i_r) + AW'(s2_d_r);

  always_ff @(posedge clk) begin
    if (rdy3) begin
      s3_left_r     <= base_s - corr;
      s3_right_r    <= base_s + corr;
      s3_lost_r     <= s2_lost_r;
      s3_spin_pos_r <= s2_spin_pos_r;
    end
  end

  // --------------------------------------------------------------------------
  // output stage: drop fraction toward zero, clamp, or pick the search spin
  // --------------------------------------------------------------------------
  function automatic logic [DRIVE_W-1:0] trunc_clamp(
    input logic signed [AW-1:0]  x,
    input logic [SPEED_W-1:0]    lim
  );
    logic signed [AW-1:0] q;
    logic signed [AW-1:0] lim_s;
    logic [DRIVE_W-1:0]   res;
    q     = x >>> GAIN_FRAC_BITS;
    // floor shift, bumped up for negatives with a fraction left over
    if (x[AW-1] && (x[GAIN_FRAC_BITS-1:0] != '0)) q = q + AW'(1);
    lim_s = $signed(AW'(lim));
    if (q > lim_s) begin
      res = DRIVE_W'(lim);
    end else if (q < -lim_s) begin
      res = -DRIVE_W'(lim);
    end else begin
      res = q[DRIVE_W-1:0];
    end
    return res;
  endfunction

  logic [DRIVE_W-1:0] spin_fwd, spin_rev;
  logic [DRIVE_W-1:0] left_nxt, right_nxt;
  logic [DRIVE_W-1:0] out_left_r, out_right_r;
  logic               out_lost_r;

  assign spin_fwd = DRIVE_W'(search_speed_r);
  assign spin_rev = -DRIVE_W'(search_speed_r);

  always_comb begin
    if (s3_lost_r) begin
      left_nxt  = s3_spin_pos_r ? spin_rev : spin_fwd;
      right_nxt = s3_spin_pos_r ? spin_fwd : spin_rev;
    end else begin
      left_nxt  = trunc_clamp(s3_left_r, drive_limit_r);
      right_nxt = trunc_clamp(s3_right_r, drive_limit_r);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_out) begin
      out_left_r  <= left_nxt;
      out_right_r <= right_nxt;
      out_lost_r  <= s3_lost_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {{PAD_W{1'b0}}, out_right_r, out_left_r};
  assign out_tuser  = out_lost_r;

`ifndef SYNTHESIS
  // search spin is always symmetric
  a_spin_symmetric: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && out_lost_r |-> $signed(out_left_r) == -$signed(out_right_r))
    else $error("search spin drives not opposite");

  // reset empties the whole pipe
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !s0_v_r && !s1_v_r && !s2_v_r && !s3_v_r && !out_v_r)
    else $error("pipe not empty after reset");

  // a lost-line frame leaves integral and last error alone
  a_lost_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
    s0_v_r && rdy1 && lost_nxt |=> $stable(err_sum_r) && $stable(last_err_r))
    else $error("state changed on lost line");

  // integral only moves when a frame enters stage 1
  a_sum_moves_on_frame: assert property (@(posedge clk) disable iff (!rst_n)
    !(s0_v_r && rdy1) |=> $stable(err_sum_r))
    else $error("integral changed without a frame");
`endif

endmodule : line_follow_pid_drive_unit
`default_nettype wire
